// ----- design/ver_pkg.sv -----
// shared constants, types and the arctangent table for the euler rotation unit
// no dependencies
package ver_pkg;

  localparam int unsigned VecW = 32;
  localparam int unsigned AngW = 16;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicW = 34;
  localparam int unsigned UnitsPerTurn = 23040;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;
  localparam logic signed [31:0] Q30One = 32'sd1073741824;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [CordicW-1:0] cval_t;

  typedef struct packed {
    cval_t s;
    cval_t c;
  } sincos_t;

  function automatic cval_t atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 34'sd536870912;
      5'd1:  atan_turn = 34'sd316933406;
      5'd2:  atan_turn = 34'sd167458907;
      5'd3:  atan_turn = 34'sd85004756;
      5'd4:  atan_turn = 34'sd42667331;
      5'd5:  atan_turn = 34'sd21354465;
      5'd6:  atan_turn = 34'sd10679838;
      5'd7:  atan_turn = 34'sd5340245;
      5'd8:  atan_turn = 34'sd2670163;
      5'd9:  atan_turn = 34'sd1335087;
      5'd10: atan_turn = 34'sd667544;
      5'd11: atan_turn = 34'sd333772;
      5'd12: atan_turn = 34'sd166886;
      5'd13: atan_turn = 34'sd83443;
      5'd14: atan_turn = 34'sd41722;
      5'd15: atan_turn = 34'sd20861;
      5'd16: atan_turn = 34'sd10430;
      5'd17: atan_turn = 34'sd5215;
      5'd18: atan_turn = 34'sd2608;
      5'd19: atan_turn = 34'sd1304;
      5'd20: atan_turn = 34'sd652;
      5'd21: atan_turn = 34'sd326;
      5'd22: atan_turn = 34'sd163;
      5'd23: atan_turn = 34'sd81;
      5'd24: atan_turn = 34'sd41;
      5'd25: atan_turn = 34'sd20;
      5'd26: atan_turn = 34'sd10;
      5'd27: atan_turn = 34'sd5;
      5'd28: atan_turn = 34'sd3;
      5'd29: atan_turn = 34'sd1;
      default: atan_turn = '0;
    endcase
  endfunction

  // product of two q30 values rounded back to q30
  function automatic logic signed [35:0] mul30(input logic signed [35:0] a,
                                               input logic signed [35:0] b);
    logic signed [71:0] p;
    p = a * b + 72'sd536870912;
    mul30 = p[65:30];
  endfunction

  function automatic logic signed [35:0] clamp_unit(input logic signed [35:0] v);
    if (v > 36'sd1073741824) clamp_unit = 36'sd1073741824;
    else if (v < -36'sd1073741824) clamp_unit = -36'sd1073741824;
    else clamp_unit = v;
  endfunction

endpackage

// ----- design/ver_sincos.sv -----
// pipelined cordic: one angle to sine and cosine in q4.30
// depends on ver_pkg
module ver_sincos (
  input  logic           clk,
  input  logic           en,
  input  ver_pkg::ang_t  angle,
  output ver_pkg::sincos_t sc
);
  import ver_pkg::*;

  localparam int unsigned NSt = CordicSteps;
  localparam int unsigned FracN = 45;
  localparam logic signed [16:0] Turn = 17'(UnitsPerTurn);

  // stage a: reduce modulo one turn
  logic [14:0] m_r;
  // stage b: m split as 45*q + r
  logic [8:0] q_r;
  logic [5:0] r_r;
  // stage c: binary angle, folded
  cval_t z0_r;
  logic  neg0_r;

  cval_t x_r [NSt];
  cval_t y_r [NSt];
  cval_t z_r [NSt];
  logic  neg_r [NSt];
  sincos_t sc_r;

  logic signed [16:0] ang_x;
  logic signed [16:0] m_nxt;
  logic [29:0] qprod;
  logic [8:0] q_nxt;
  logic [14:0] qx45;
  logic [14:0] r_full;
  logic [22:0] frac_tab [FracN];
  logic [31:0] bam;
  logic signed [32:0] zs;
  cval_t zf;
  logic  negf;

  always_comb begin
    ang_x = 17'(angle);
    if (ang_x >= Turn) m_nxt = ang_x - Turn;
    else if (ang_x >= 17'sd0) m_nxt = ang_x;
    else if (ang_x >= -Turn) m_nxt = ang_x + Turn;
    else m_nxt = ang_x + (Turn <<< 1);
  end

  // binary angle = q*2^23 + floor((r*2^23 + 22)/45)
  always_comb begin
    qprod = 30'(m_r) * 30'd46604;
    q_nxt = qprod[29:21];
    qx45 = 15'(q_nxt) * 15'd45;
    r_full = m_r - qx45;
  end

  genvar t;
  generate
    for (t = 0; t < FracN; t++) begin : g_frac
      localparam logic [22:0] FracVal = 23'((64'(t) * 64'd8388608 + 64'd22) / 64'd45);
      assign frac_tab[t] = FracVal;
    end
  endgenerate

  always_comb begin
    bam = {q_r, frac_tab[r_r]};
    zs = $signed({bam[31], bam});
    negf = 1'b0;
    zf = CordicW'(zs);
    if (zs > 33'sd1073741824) begin
      zf = CordicW'(zs - 33'sd2147483648);
      negf = 1'b1;
    end else if (zs < -33'sd1073741824) begin
      zf = CordicW'(zs + 33'sd2147483648);
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt[14:0];
      q_r <= q_nxt;
      r_r <= r_full[5:0];
      z0_r <= zf;
      neg0_r <= negf;
    end
  end

  genvar g;
  generate
    for (g = 0; g < NSt; g++) begin : g_st
      cval_t xi, yi, zi;
      logic  ni;
      if (g == 0) begin : g_first
        assign xi = CordicStart;
        assign yi = '0;
        assign zi = z0_r;
        assign ni = neg0_r;
      end else begin : g_rest
        assign xi = x_r[g-1];
        assign yi = y_r[g-1];
        assign zi = z_r[g-1];
        assign ni = neg_r[g-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (zi >= 0) begin
            x_r[g] <= xi - (yi >>> g);
            y_r[g] <= yi + (xi >>> g);
            z_r[g] <= zi - atan_turn(5'(g));
          end else begin
            x_r[g] <= xi + (yi >>> g);
            y_r[g] <= yi - (xi >>> g);
            z_r[g] <= zi + atan_turn(5'(g));
          end
          neg_r[g] <= ni;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.c <= neg_r[NSt-1] ? -x_r[NSt-1] : x_r[NSt-1];
      sc_r.s <= neg_r[NSt-1] ? -y_r[NSt-1] : y_r[NSt-1];
    end
  end

  assign sc = sc_r;
endmodule

// ----- design/vector_euler_rotate_unit.sv -----
// top level of the z-y-x euler rotation unit
// depends on ver_pkg and ver_sincos
// Accepts one vector every cycle whenever busy is low; busy is always low, so an
// item can follow each cycle. The path from transfer to result runs through the
// 30-stage cordic plus angle reduction, matrix build and dot-product stages.
// Results appear for one cycle with out_valid and cannot be held off.
module vector_euler_rotate_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ver_pkg::vec_t in_vec_x,
  input  ver_pkg::vec_t in_vec_y,
  input  ver_pkg::vec_t in_vec_z,
  input  ver_pkg::ang_t in_angle_alpha,
  input  ver_pkg::ang_t in_angle_beta,
  input  ver_pkg::ang_t in_angle_gamma,
  output logic          out_valid,
  output ver_pkg::vec_t out_rot_x,
  output ver_pkg::vec_t out_rot_y,
  output ver_pkg::vec_t out_rot_z,
  output logic          out_saturated
);
  import ver_pkg::*;

  localparam int unsigned CosLat = CordicSteps + 4;
  localparam int unsigned Lat = CosLat + 6;

  typedef logic signed [35:0] q_t;

  logic en;
  assign en = 1'b1;
  assign busy = 1'b0;

  sincos_t sa, sb, sg;
  ver_sincos u_a (.clk, .en, .angle(in_angle_alpha), .sc(sa));
  ver_sincos u_b (.clk, .en, .angle(in_angle_beta),  .sc(sb));
  ver_sincos u_g (.clk, .en, .angle(in_angle_gamma), .sc(sg));

  logic [Lat-1:0] vld_r;
  vec_t vx_r [CosLat];
  vec_t vy_r [CosLat];
  vec_t vz_r [CosLat];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Lat-2:0], start};
  end

  always_ff @(posedge clk) begin
    vx_r[0] <= in_vec_x;
    vy_r[0] <= in_vec_y;
    vz_r[0] <= in_vec_z;
    for (int i = 1; i < CosLat; i++) begin
      vx_r[i] <= vx_r[i-1];
      vy_r[i] <= vy_r[i-1];
      vz_r[i] <= vz_r[i-1];
    end
  end

  // matrix stage 1: first products
  q_t sb1_r, sg1_r, cg1_r, casb_r, sasb_r, r0_r, r3_r, r7_r, r8_r;
  q_t sacg_r, sasg_r, cacg_r, casg_r;
  vec_t v1x_r, v1y_r, v1z_r;
  always_ff @(posedge clk) begin
    casb_r <= mul30(36'(sa.c), 36'(sb.s));
    sasb_r <= mul30(36'(sa.s), 36'(sb.s));
    r0_r <= mul30(36'(sa.c), 36'(sb.c));
    r3_r <= mul30(36'(sa.s), 36'(sb.c));
    r7_r <= mul30(36'(sb.c), 36'(sg.s));
    r8_r <= mul30(36'(sb.c), 36'(sg.c));
    sacg_r <= mul30(36'(sa.s), 36'(sg.c));
    sasg_r <= mul30(36'(sa.s), 36'(sg.s));
    cacg_r <= mul30(36'(sa.c), 36'(sg.c));
    casg_r <= mul30(36'(sa.c), 36'(sg.s));
    sb1_r <= 36'(sb.s);
    sg1_r <= 36'(sg.s);
    cg1_r <= 36'(sg.c);
    v1x_r <= vx_r[CosLat-1];
    v1y_r <= vy_r[CosLat-1];
    v1z_r <= vz_r[CosLat-1];
  end

  // matrix stage 2: second products and clamp
  q_t m_r [9];
  vec_t v2x_r, v2y_r, v2z_r;
  always_ff @(posedge clk) begin
    m_r[0] <= clamp_unit(r0_r);
    m_r[1] <= clamp_unit(mul30(casb_r, sg1_r) - sacg_r);
    m_r[2] <= clamp_unit(mul30(casb_r, cg1_r) + sasg_r);
    m_r[3] <= clamp_unit(r3_r);
    m_r[4] <= clamp_unit(mul30(sasb_r, sg1_r) + cacg_r);
    m_r[5] <= clamp_unit(mul30(sasb_r, cg1_r) - casg_r);
    m_r[6] <= clamp_unit(-sb1_r);
    m_r[7] <= clamp_unit(r7_r);
    m_r[8] <= clamp_unit(r8_r);
    v2x_r <= v1x_r;
    v2y_r <= v1y_r;
    v2z_r <= v1z_r;
  end

  // stage 3: nine products
  logic signed [63:0] p_r [9];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p_r[3*k]   <= 64'(v2x_r) * 64'(m_r[3*k]);
      p_r[3*k+1] <= 64'(v2y_r) * 64'(m_r[3*k+1]);
      p_r[3*k+2] <= 64'(v2z_r) * 64'(m_r[3*k+2]);
    end
  end

  // stage 4: row sums
  logic signed [65:0] acc_r [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++)
      acc_r[k] <= 66'(p_r[3*k]) + 66'(p_r[3*k+1]) + 66'(p_r[3*k+2]) + 66'sd536870912;
  end

  // stage 5: round, saturate
  vec_t o_r [3];
  logic [2:0] s_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if ($signed(acc_r[k][65:30]) > 36'sd2147483647) begin
        o_r[k] <= 32'sh7fffffff;
        s_r[k] <= 1'b1;
      end else if ($signed(acc_r[k][65:30]) < -36'sd2147483648) begin
        o_r[k] <= 32'sh80000000;
        s_r[k] <= 1'b1;
      end else begin
        o_r[k] <= acc_r[k][61:30];
        s_r[k] <= 1'b0;
      end
    end
  end

  // output registers
  vec_t ox_r, oy_r, oz_r;
  logic osat_r;
  always_ff @(posedge clk) begin
    ox_r <= o_r[0];
    oy_r <= o_r[1];
    oz_r <= o_r[2];
    osat_r <= |s_r;
  end

  assign out_valid = vld_r[Lat-1];
  assign out_rot_x = ox_r;
  assign out_rot_y = oy_r;
  assign out_rot_z = oz_r;
  assign out_saturated = osat_r;
endmodule

// ----- design/ver_checker.sv -----
// port-level checks for the euler rotation unit, bound to the top level
// depends on ver_pkg
module ver_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input ver_pkg::vec_t out_rot_x,
  input logic          out_saturated
);
  import ver_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(start, 40) && $past(rst_n, 40) |-> !out_valid)
    else $error("result without transfer");
  a_one_per: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, 40) && $past(rst_n, 40) |-> out_valid)
    else $error("transfer lost");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_rot_x, out_saturated}))
    else $error("unknown result");
endmodule

bind vector_euler_rotate_unit ver_checker u_ver_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_rot_x, .out_saturated
);

// ----- tb/sv/tb.sv -----
// self-checking testbench for vector_euler_rotate_unit: z-y-x euler rotation of q16.16 vectors
// depends on ver_pkg and the unit's rtl; holds its own cordic based predictor and scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ver_pkg::*;

  typedef struct {
    vec_t x;
    vec_t y;
    vec_t z;
    ang_t a;
    ang_t b;
    ang_t g;
  } vec_item_t;

  typedef struct {
    vec_t rx;
    vec_t ry;
    vec_t rz;
    logic sat;
  } rot_res_t;

  localparam int Latency = 40;
  localparam longint CycleLimit = 400000;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fshr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint unit_clip(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                      81, 41, 20, 10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic void angle_sincos(input ang_t ang, output longint s, output longint c);
    longint m, z, x, y, dx, dy;
    logic [95:0] bam;
    logic [31:0] b32;
    bit flip;
    flip = 0;
    m = longint'(ang) % longint'(UnitsPerTurn);
    if (m < 0) m += longint'(UnitsPerTurn);
    bam = ((96'(m) << 32) + 96'(UnitsPerTurn / 2)) / 96'(UnitsPerTurn);
    b32 = bam[31:0];
    z = longint'(signed'(b32));
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic vec_t row_dot(vec_item_t it, longint r0, longint r1, longint r2,
                                   ref logic sat);
    longint acc, q;
    acc = longint'(it.x) * r0 + longint'(it.y) * r1 + longint'(it.z) * r2;
    q = fshr(acc + (64'sd1 <<< 29), 30);
    if (q > 64'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return vec_t'(q);
  endfunction

  function automatic rot_res_t rotate_vector(vec_item_t it);
    longint sa, ca, sb, cb, sg, cg, casb, sasb;
    longint r[9];
    rot_res_t res;
    logic sat;
    angle_sincos(it.a, sa, ca);
    angle_sincos(it.b, sb, cb);
    angle_sincos(it.g, sg, cg);
    casb = qmul(ca, sb);
    sasb = qmul(sa, sb);
    r[0] = qmul(ca, cb);
    r[1] = qmul(casb, sg) - qmul(sa, cg);
    r[2] = qmul(casb, cg) + qmul(sa, sg);
    r[3] = qmul(sa, cb);
    r[4] = qmul(sasb, sg) + qmul(ca, cg);
    r[5] = qmul(sasb, cg) - qmul(ca, sg);
    r[6] = -sb;
    r[7] = qmul(cb, sg);
    r[8] = qmul(cb, cg);
    foreach (r[k]) r[k] = unit_clip(r[k]);
    sat = 0;
    res.rx = row_dot(it, r[0], r[1], r[2], sat);
    res.ry = row_dot(it, r[3], r[4], r[5], sat);
    res.rz = row_dot(it, r[6], r[7], r[8], sat);
    res.sat = sat;
    return res;
  endfunction

  class rotation_scoreboard;
    rot_res_t pending[$];
    int errors;

    function void note_transfer(vec_item_t it);
      pending.push_back(rotate_vector(it));
    endfunction

    function void check_result(rot_res_t got);
      rot_res_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no expected value waiting");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.rx !== exp_r.rx) begin
        $error("rot_x expected %0d actual %0d", exp_r.rx, got.rx);
        errors++;
      end
      if (got.ry !== exp_r.ry) begin
        $error("rot_y expected %0d actual %0d", exp_r.ry, got.ry);
        errors++;
      end
      if (got.rz !== exp_r.rz) begin
        $error("rot_z expected %0d actual %0d", exp_r.rz, got.rz);
        errors++;
      end
      if (got.sat !== exp_r.sat) begin
        $error("saturated expected %0b actual %0b", exp_r.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  vec_t in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  ang_t in_angle_alpha = '0, in_angle_beta = '0, in_angle_gamma = '0;
  logic out_valid;
  vec_t out_rot_x, out_rot_y, out_rot_z;
  logic out_saturated;

  rotation_scoreboard sb = new();
  longint cycles = 0;
  bit no_idle = 0;

  vector_euler_rotate_unit dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    rot_res_t got;
    cycles <= cycles + 1;
    if (rst_n && start && !busy) sb.note_transfer('{in_vec_x, in_vec_y, in_vec_z,
        in_angle_alpha, in_angle_beta, in_angle_gamma});
    if (rst_n && out_valid) begin
      got = '{out_rot_x, out_rot_y, out_rot_z, out_saturated};
      sb.check_result(got);
    end
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_vector(vec_item_t it);
    while (!no_idle && $urandom_range(99) < 15) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_vec_x <= it.x;
    in_vec_y <= it.y;
    in_vec_z <= it.z;
    in_angle_alpha <= it.a;
    in_angle_beta <= it.b;
    in_angle_gamma <= it.g;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic vec_t rand_vec();
    case ($urandom_range(4))
      0: return vec_t'($urandom);
      1: return vec_t'($urandom_range(8));
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return vec_t'(int'($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic ang_t rand_ang();
    case ($urandom_range(5))
      0: return ang_t'($urandom);
      1: return ang_t'(int'($urandom_range(16)) * 1440 - 11520);
      default: return ang_t'(int'($urandom_range(46080)) - 23040);
    endcase
  endfunction

  task automatic wait_drained();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    vec_item_t it;
    vec_t vx[6] = '{32'h00010000, 32'h7fffffff, 32'h80000000, 32'hffff0000, 0, 32'h12345678};
    ang_t an[8] = '{0, 5760, -5760, 11520, 23040, -23040, 16'sh7fff, 16'sh8000};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 24; i++) begin
      it = '{vx[i % 6], vx[(i + 1) % 6], vx[(i + 3) % 6], an[i % 8], an[(i + 3) % 8],
             an[(i * 5) % 8]};
      send_vector(it);
    end
    wait_drained();
    for (int n = 0; n < 1650; n++) begin
      no_idle = (n >= 600 && n < 800);
      if (n == 1000) wait_drained();
      it = '{rand_vec(), rand_vec(), rand_vec(), rand_ang(), rand_ang(), rand_ang()};
      send_vector(it);
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
